// ===== src/ase_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared types, character codes and defaults for the add/subtract expression evaluator
// no dependencies; imported by ase_front, ase_back and the top level (ase_queue is generic and does not import it)

package ase_pkg;

   // defaults for the top-level parameters, and the depth of both queues
   localparam int DEF_MAX_NESTING = 16;
   localparam int DEF_VALUE_BITS  = 32;
   localparam int QUEUE_DEPTH     = 2;

   // width of the result value port
   localparam int RSP_VALUE_W = 32;

   // item kinds on the request channel
   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_END  = 1'b1;

   // ascii codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [2:0] {
      TOK_DIGIT = 3'd0,
      TOK_OPEN  = 3'd1,
      TOK_CLOSE = 3'd2,
      TOK_PLUS  = 3'd3,
      TOK_MINUS = 3'd4,
      TOK_OTHER = 3'd5,
      TOK_END   = 3'd6
   } tok_kind_type;

   typedef enum logic [2:0] {
      ERR_OK        = 3'd0,
      ERR_EMPTY     = 3'd1,
      ERR_VALUE     = 3'd2,
      ERR_OPERATOR  = 3'd3,
      ERR_MISSING   = 3'd4,
      ERR_UNMATCHED = 3'd5,
      ERR_DEEP      = 3'd6
   } err_type;

   typedef enum logic [2:0] {
      PH_EXPECT = 3'b001,
      PH_NUMBER = 3'b010,
      PH_AFTER  = 3'b100
   } phase_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [3:0]   digit;
   } token_type;

   typedef struct packed {
      logic [RSP_VALUE_W-1:0] value;
      err_type                error;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/ase_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// small register queue with push/full and pop/empty handshakes
// generic in item type and depth; used between front and back and on the result side

module ase_queue #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type wr_item,
   output logic          full,
   input  wire logic     pop,
   output item_type      rd_item,
   output logic          empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

// ===== src/ase_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// front end: classifies each request beat into a token and queues it
// depends on ase_pkg and ase_queue

module ase_front #(
   parameter int QDEPTH = ase_pkg::QUEUE_DEPTH
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_op,
   input  wire logic [7:0]    req_char_code,
   input  wire logic          push,
   output logic               full,
   output ase_pkg::token_type tok,
   output logic               tok_valid,
   input  wire logic          tok_pop
);

   import ase_pkg::*;

   token_type  cls;
   logic       tok_empty;

   always_comb begin
      cls.digit = req_char_code[3:0];
      if (req_op == OP_END) begin
         cls.kind = TOK_END;
      end else if (req_char_code >= CHAR_ZERO && req_char_code <= CHAR_NINE) begin
         cls.kind = TOK_DIGIT;
      end else if (req_char_code == CHAR_OPEN) begin
         cls.kind = TOK_OPEN;
      end else if (req_char_code == CHAR_CLOSE) begin
         cls.kind = TOK_CLOSE;
      end else if (req_char_code == CHAR_PLUS) begin
         cls.kind = TOK_PLUS;
      end else if (req_char_code == CHAR_MINUS) begin
         cls.kind = TOK_MINUS;
      end else begin
         cls.kind = TOK_OTHER;
      end
   end

   ase_queue #(
      .item_type (token_type),
      .DEPTH     (QDEPTH)
   ) u_tok_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_item (cls),
      .full    (full),
      .pop     (tok_pop),
      .rd_item (tok),
      .empty   (tok_empty)
   );

   assign tok_valid = !tok_empty;

endmodule

`default_nettype wire

// ===== src/ase_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// back end: evaluates tokens, keeps the nesting stack and produces one result per end token
// depends on ase_pkg; the current level lives in registers, outer levels in a stack memory

module ase_back #(
   parameter int MAX_NESTING = ase_pkg::DEF_MAX_NESTING,
   parameter int VALUE_BITS  = ase_pkg::DEF_VALUE_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ase_pkg::token_type tok,
   input  wire logic               tok_valid,
   output logic                    tok_pop,
   output ase_pkg::rsp_type        rsp,
   output logic                    rsp_push,
   input  wire logic               rsp_full
);

   import ase_pkg::*;

   localparam int ADDR_W = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
   localparam int ENTRY_W = VALUE_BITS + 1;

   // stack memory: {negative, sum} of each saved outer level
   logic [ENTRY_W-1:0]    stack_mem [MAX_NESTING];
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [ENTRY_W-1:0]    mem_wdata;
   logic                  mem_re;
   logic [ADDR_W-1:0]     mem_raddr;

   logic [VALUE_BITS-1:0] cur_sum_ff, cur_sum_in;
   logic                  cur_neg_ff, cur_neg_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   phase_type             phase_ff, phase_in;
   logic [ADDR_W-1:0]     depth_ff, depth_in;
   err_type               err_ff, err_in;
   logic                  seen_ff, seen_in;
   logic [ENTRY_W-1:0]    outer_ff, outer_in;
   logic                  outer_mem_ff, outer_mem_in;

   logic [VALUE_BITS-1:0] closed_sum;
   logic [VALUE_BITS-1:0] outer_sum;
   logic                  outer_neg;
   logic [ENTRY_W-1:0]    outer_cur;
   logic [VALUE_BITS-1:0] digit_ext;
   logic [VALUE_BITS-1:0] acc_times_ten;
   logic                  at_limit;
   err_type               end_err;

   assign tok_pop = tok_valid && (tok.kind != TOK_END || !rsp_full);

   assign digit_ext     = {{(VALUE_BITS - 4){1'b0}}, tok.digit};
   assign acc_times_ten = (acc_ff << 3) + (acc_ff << 1);
   assign at_limit      = (depth_ff == ADDR_W'(MAX_NESTING - 1));

   // sum of the current level with the pending number folded in
   always_comb begin
      if (phase_ff == PH_NUMBER) begin
         closed_sum = cur_neg_ff ? cur_sum_ff - acc_ff : cur_sum_ff + acc_ff;
      end else begin
         closed_sum = cur_sum_ff;
      end
   end

   // the enclosing level comes from the memory read just after a pop
   assign outer_cur = outer_mem_ff ? rd_data_ff : outer_ff;
   assign outer_sum = outer_cur[VALUE_BITS-1:0];
   assign outer_neg = outer_cur[VALUE_BITS];

   always_comb begin
      if (err_ff != ERR_OK) begin
         end_err = err_ff;
      end else if (!seen_ff) begin
         end_err = ERR_EMPTY;
      end else if (depth_ff != '0) begin
         end_err = ERR_MISSING;
      end else begin
         end_err = ERR_OK;
      end
   end

   always_comb begin
      cur_sum_in   = cur_sum_ff;
      cur_neg_in   = cur_neg_ff;
      acc_in       = acc_ff;
      phase_in     = phase_ff;
      depth_in     = depth_ff;
      err_in       = err_ff;
      seen_in      = seen_ff;
      outer_in     = outer_cur;
      outer_mem_in = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = depth_ff;
      mem_wdata    = {cur_neg_ff, cur_sum_ff};
      mem_re       = 1'b0;
      mem_raddr    = depth_ff - ADDR_W'(2);
      rsp_push     = 1'b0;
      rsp.error    = end_err;
      rsp.value    = (end_err == ERR_OK) ? RSP_VALUE_W'($signed(closed_sum)) : '0;

      if (tok_pop) begin
         if (tok.kind == TOK_END) begin
            rsp_push   = 1'b1;
            cur_sum_in = '0;
            cur_neg_in = 1'b0;
            acc_in     = '0;
            phase_in   = PH_EXPECT;
            depth_in   = '0;
            err_in     = ERR_OK;
            seen_in    = 1'b0;
         end else begin
            seen_in = 1'b1;
            if (err_ff == ERR_OK) begin
               unique case (phase_ff) inside
                  PH_EXPECT: begin
                     unique case (tok.kind)
                        TOK_DIGIT: begin
                           acc_in   = digit_ext;
                           phase_in = PH_NUMBER;
                        end
                        TOK_OPEN: begin
                           if (at_limit) begin
                              err_in = ERR_DEEP;
                           end else begin
                              mem_we     = 1'b1;
                              outer_in   = {cur_neg_ff, cur_sum_ff};
                              cur_sum_in = '0;
                              cur_neg_in = 1'b0;
                              depth_in   = depth_ff + 1'b1;
                           end
                        end
                        default: begin
                           err_in = ERR_VALUE;
                        end
                     endcase
                  end
                  PH_NUMBER, PH_AFTER: begin
                     if (phase_ff == PH_NUMBER && tok.kind == TOK_DIGIT) begin
                        acc_in = acc_times_ten + digit_ext;
                     end else begin
                        // close any pending number first
                        cur_sum_in = closed_sum;
                        acc_in     = '0;
                        phase_in   = PH_AFTER;
                        unique case (tok.kind) inside
                           TOK_PLUS, TOK_MINUS: begin
                              cur_neg_in = (tok.kind == TOK_MINUS);
                              phase_in   = PH_EXPECT;
                           end
                           TOK_CLOSE: begin
                              if (depth_ff == '0) begin
                                 err_in = ERR_UNMATCHED;
                              end else begin
                                 cur_sum_in   = outer_neg ? outer_sum - closed_sum
                                                          : outer_sum + closed_sum;
                                 cur_neg_in   = outer_neg;
                                 depth_in     = depth_ff - 1'b1;
                                 mem_re       = 1'b1;
                                 outer_mem_in = 1'b1;
                              end
                           end
                           default: begin
                              err_in = ERR_OPERATOR;
                           end
                        endcase
                     end
                  end
                  default: begin
                     phase_in = PH_EXPECT;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_sum_ff   <= '0;
         cur_neg_ff   <= 1'b0;
         acc_ff       <= '0;
         phase_ff     <= PH_EXPECT;
         depth_ff     <= '0;
         err_ff       <= ERR_OK;
         seen_ff      <= 1'b0;
         outer_mem_ff <= 1'b0;
      end else begin
         cur_sum_ff   <= cur_sum_in;
         cur_neg_ff   <= cur_neg_in;
         acc_ff       <= acc_in;
         phase_ff     <= phase_in;
         depth_ff     <= depth_in;
         err_ff       <= err_in;
         seen_ff      <= seen_in;
         outer_mem_ff <= outer_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      outer_ff <= outer_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[mem_raddr];
      end
   end

endmodule

`default_nettype wire

// ===== src/add_sub_paren_expression_evaluator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// top level of the streaming add/subtract/parenthesis expression evaluator
// depends on ase_pkg, ase_front, ase_back and ase_queue
//
//   channel   | ports                                  | beat taken when
//   ----------+----------------------------------------+-------------------
//   request   | req_op, req_char_code, push, full      | push && !full
//   response  | rsp_value, rsp_error_code, empty, pop  | pop && !empty
//
// one character beat per cycle sustained while the response queue has room;
// the evaluator updates the current level (multiply by ten and add, or close
// and fold) combinationally and registers it for every token taken
// a result reaches the response ports via the front and response queues
// reset clears both queues and the evaluator; the stack memory needs no clearing
// full rises once two tokens wait; an end token holds in the front queue
// while the response queue is full, and the front takes one more beat
// behind it and then holds full high

module add_sub_paren_expression_evaluator #(
   parameter int MAX_NESTING = ase_pkg::DEF_MAX_NESTING,
   parameter int VALUE_BITS  = ase_pkg::DEF_VALUE_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_op,
   input  wire logic [7:0]                          req_char_code,
   input  wire logic                                push,
   output logic                                     full,
   output logic signed [ase_pkg::RSP_VALUE_W-1:0]   rsp_value,
   output logic [2:0]                               rsp_error_code,
   output logic                                     empty,
   input  wire logic                                pop
);

   import ase_pkg::*;

   // token path between front and back
   token_type tok;
   logic      tok_valid;
   logic      tok_pop;

   // result path into the response queue
   rsp_type   rsp_new;
   logic      rsp_push;
   logic      rsp_full;
   rsp_type   rsp_head;

   // classify and queue incoming characters
   ase_front #(
      .QDEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_op        (req_op),
      .req_char_code (req_char_code),
      .push          (push),
      .full          (full),
      .tok           (tok),
      .tok_valid     (tok_valid),
      .tok_pop       (tok_pop)
   );

   // evaluate tokens against the nesting stack
   ase_back #(
      .MAX_NESTING (MAX_NESTING),
      .VALUE_BITS  (VALUE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok       (tok),
      .tok_valid (tok_valid),
      .tok_pop   (tok_pop),
      .rsp       (rsp_new),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   // results wait here until the consumer pops them
   ase_queue #(
      .item_type (rsp_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_item (rsp_new),
      .full    (rsp_full),
      .pop     (pop),
      .rd_item (rsp_head),
      .empty   (empty)
   );

   assign rsp_value      = $signed(rsp_head.value);
   assign rsp_error_code = rsp_head.error;

endmodule

`default_nettype wire
